// ===== rtl/integer_to_russian_word_tokens_assert.svh =====
// Assertion macros for the Russian number speller.
`ifndef INTEGER_TO_RUSSIAN_WORD_TOKENS_ASSERT_SVH
`define INTEGER_TO_RUSSIAN_WORD_TOKENS_ASSERT_SVH

// Clocked property, off during reset.
`define ITRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold.
`define ITRW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/itrw_pkg.sv =====
`default_nettype none

package itrw_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned WordW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned CountW    = $clog2(ValueW);

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [WordW-1:0]  word_t;

  localparam word_t W_ZERO     = 6'd0;
  localparam word_t W_MINUS    = 6'd1;
  localparam word_t W_HUNDRED  = 6'd2;
  localparam word_t W_TENS     = 6'd11;
  localparam word_t W_ONE      = 6'd19;
  localparam word_t W_TWO      = 6'd21;
  localparam word_t W_THREE    = 6'd23;
  localparam word_t W_BILLION  = 6'd40;
  localparam word_t W_MILLION  = 6'd43;
  localparam word_t W_THOUSAND = 6'd46;
  localparam word_t W_UNIT     = 6'd49;

  localparam logic [1:0] FORM_ONE  = 2'd0;
  localparam logic [1:0] FORM_FEW  = 2'd1;
  localparam logic [1:0] FORM_MANY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    GRP_BILLION,
    GRP_MILLION,
    GRP_THOUSAND,
    GRP_UNIT
  } group_e;

  typedef enum logic [1:0] {
    SLOT_HUNDRED,
    SLOT_TENS,
    SLOT_ONES,
    SLOT_NOUN
  } slot_e;

  typedef struct packed {
    logic busy;
    logic done;
  } dbl_status_t;

endpackage

`default_nettype wire

// ===== rtl/itrw_dabble.sv =====
`default_nettype none

module itrw_dabble (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          start_i,
  input  wire logic [itrw_pkg::ValueW-1:0]                   mag_i,
  output itrw_pkg::dbl_status_t                              status_o,
  output itrw_pkg::digit_t [itrw_pkg::NumDigits-1:0]         digits_o
);
  import itrw_pkg::*;

  logic [ValueW-1:0]           bin_q, bin_d;
  digit_t [NumDigits-1:0]      bcd_q, bcd_d;
  digit_t [NumDigits-1:0]      adj;
  logic [CountW-1:0]           cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd_q[i] >= DigitW'(5)) ? bcd_q[i] + DigitW'(3) : bcd_q[i];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[NumDigits-1][DigitW-2:0], adj[NumDigits-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + CountW'(1);
      if (cnt_q == CountW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign digits_o      = bcd_q;

endmodule

`default_nettype wire

// ===== rtl/itrw_speller.sv =====
`default_nettype none

module itrw_speller (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output logic                                           in_ready_o,
  input  wire logic [itrw_pkg::ValueW-1:0]               value_i,
  input  wire logic                                      unit_gender_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output itrw_pkg::word_t                                word_code_o,
  output logic                                           last_word_o,
  output logic                                           start_o,
  output logic [itrw_pkg::ValueW-1:0]                    mag_o,
  input  itrw_pkg::dbl_status_t                          status_i,
  input  itrw_pkg::digit_t [itrw_pkg::NumDigits-1:0]     digits_i
);
  import itrw_pkg::*;

  state_e  state_q, state_d;
  group_e  grp_q, grp_d;
  slot_e   slot_q, slot_d;
  logic    neg_q, neg_d;
  logic    zero_q, zero_d;
  logic    fem_q, fem_d;
  logic    out_valid_q, out_valid_d;
  word_t   word_q;
  logic    last_q;

  logic    accept;
  logic    load_ok;
  logic    load;
  word_t   load_word;
  logic    load_last;

  digit_t  dig_h, dig_t, dig_o;
  logic    fem_grp;
  word_t   noun_base;
  logic [4:0] rem;
  logic [1:0] form;
  logic    grp_zero;
  logic    skip;
  logic    emit_en;
  word_t   emit_code;
  logic    advance;
  logic    done_item;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign load_ok = !out_valid_q || out_ready_i;
  assign mag_o   = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;

  // Group digits and noun base.
  always_comb begin
    unique case (grp_q)
      GRP_BILLION: begin
        dig_h     = '0;
        dig_t     = '0;
        dig_o     = digits_i[9];
        fem_grp   = 1'b0;
        noun_base = W_BILLION;
      end
      GRP_MILLION: begin
        dig_h     = digits_i[8];
        dig_t     = digits_i[7];
        dig_o     = digits_i[6];
        fem_grp   = 1'b0;
        noun_base = W_MILLION;
      end
      GRP_THOUSAND: begin
        dig_h     = digits_i[5];
        dig_t     = digits_i[4];
        dig_o     = digits_i[3];
        fem_grp   = 1'b1;
        noun_base = W_THOUSAND;
      end
      default: begin
        dig_h     = digits_i[2];
        dig_t     = digits_i[1];
        dig_o     = digits_i[0];
        fem_grp   = fem_q;
        noun_base = W_UNIT;
      end
    endcase
  end

  // Word of the current slot.
  always_comb begin
    rem      = (dig_t == DigitW'(1)) ? 5'd10 + {1'b0, dig_o} : {1'b0, dig_o};
    grp_zero = (dig_h == '0) && (dig_t == '0) && (dig_o == '0);
    skip     = (state_q == ST_EMIT) && (slot_q == SLOT_HUNDRED) &&
               (grp_q != GRP_UNIT) && grp_zero;
    if (dig_t == DigitW'(1)) begin
      form = FORM_MANY;
    end else if (dig_o == DigitW'(1)) begin
      form = FORM_ONE;
    end else if ((dig_o >= DigitW'(2)) && (dig_o <= DigitW'(4))) begin
      form = FORM_FEW;
    end else begin
      form = FORM_MANY;
    end
    unique case (slot_q)
      SLOT_HUNDRED: begin
        emit_en   = (dig_h != '0);
        emit_code = W_HUNDRED + {2'b00, dig_h} - word_t'(1);
      end
      SLOT_TENS: begin
        emit_en   = (dig_t >= DigitW'(2));
        emit_code = W_TENS + {2'b00, dig_t} - word_t'(2);
      end
      SLOT_ONES: begin
        emit_en = (rem != '0);
        if (rem == 5'd1) begin
          emit_code = W_ONE + {5'd0, fem_grp};
        end else if (rem == 5'd2) begin
          emit_code = W_TWO + {5'd0, fem_grp};
        end else begin
          emit_code = W_THREE + {1'b0, rem} - word_t'(3);
        end
      end
      default: begin
        emit_en   = 1'b1;
        emit_code = noun_base + {4'd0, form};
      end
    endcase
    advance   = (state_q == ST_EMIT) && !skip && (!emit_en || load_ok);
    done_item = advance && (slot_q == SLOT_NOUN) && (grp_q == GRP_UNIT);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (status_i.done) state_d = ST_PRE;
      end
      ST_PRE: begin
        if (!(neg_q || zero_q) || load_ok) state_d = ST_EMIT;
      end
      default: begin
        if (done_item) state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control.
  always_comb begin
    grp_d     = grp_q;
    slot_d    = slot_q;
    neg_d     = neg_q;
    zero_d    = zero_q;
    fem_d     = fem_q;
    start_o   = 1'b0;
    load      = 1'b0;
    load_word = emit_code;
    load_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d   = value_i[ValueW-1];
          zero_d  = (value_i == '0);
          fem_d   = unit_gender_i;
          start_o = 1'b1;
        end
      end
      ST_CONV: begin
        if (status_i.done) begin
          grp_d  = GRP_BILLION;
          slot_d = SLOT_HUNDRED;
        end
      end
      ST_PRE: begin
        if ((neg_q || zero_q) && load_ok) begin
          load      = 1'b1;
          load_word = zero_q ? W_ZERO : W_MINUS;
        end
      end
      default: begin
        if (skip) begin
          grp_d = group_e'(grp_q + 2'd1);
        end else if (advance) begin
          load      = emit_en;
          load_last = done_item;
          if (slot_q == SLOT_NOUN) begin
            slot_d = SLOT_HUNDRED;
            if (grp_q != GRP_UNIT) grp_d = group_e'(grp_q + 2'd1);
          end else begin
            slot_d = slot_e'(slot_q + 2'd1);
          end
        end
      end
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      grp_q       <= GRP_BILLION;
      slot_q      <= SLOT_HUNDRED;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      grp_q       <= grp_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    fem_q  <= fem_d;
    if (load) begin
      word_q <= load_word;
      last_q <= load_last;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign word_code_o = word_q;
  assign last_word_o = last_q;

endmodule

`default_nettype wire

// ===== rtl/integer_to_russian_word_tokens.sv =====
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o    value_i[31:0], unit_gender_i
// out      out_valid_o/out_ready_i  word_code_o[5:0], last_word_o
//
// One number is handled in order: accept, the shift-add-3 BCD conversion,
// its done flag, the sign or zero word when one is needed, then one pass over
// the four digit groups with one word slot per cycle while the output is
// taken. An all-zero billion, million or thousand group is skipped.
// Reset returns the sequencer to idle. Output stall holds the word register
// and holds the slot sequencer at the next slot that has a word to emit.
`default_nettype none
`include "integer_to_russian_word_tokens_assert.svh"

module integer_to_russian_word_tokens (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [itrw_pkg::ValueW-1:0]     value_i,
  input  wire logic                            unit_gender_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [itrw_pkg::WordW-1:0]           word_code_o,
  output logic                                 last_word_o
);
  import itrw_pkg::*;

  logic                    start;
  logic [ValueW-1:0]       mag;
  dbl_status_t             status;
  digit_t [NumDigits-1:0]  digits;

  itrw_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .mag_i    (mag),
    .status_o (status),
    .digits_o (digits)
  );

  itrw_speller u_speller (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .unit_gender_i (unit_gender_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_code_o   (word_code_o),
    .last_word_o   (last_word_o),
    .start_o       (start),
    .mag_o         (mag),
    .status_i      (status),
    .digits_i      (digits)
  );

  `ITRW_ASSERT(a_in_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after transfer")
  `ITRW_ASSERT_NEVER(a_ready_while_conv, status.busy && in_ready_o, "ready during conversion")
  `ITRW_ASSERT(a_done_pulse, status.done |=> !status.done, "conversion done not a pulse")
  `ITRW_ASSERT_NEVER(a_start_while_busy, start && status.busy, "start during conversion")

endmodule

`default_nettype wire

// ===== tb/sv/integer_to_russian_word_tokens_test.sv =====
`timescale 1ns / 100ps

module integer_to_russian_word_tokens_test;
  import itrw_pkg::*;

  localparam int NumDirected = 25;
  localparam int NumRandom   = 225;
  localparam word_t W_ONE_F  = W_ONE + 6'd1;
  localparam word_t W_TWO_F  = W_TWO + 6'd1;

  typedef struct packed {
    logic [31:0]     value;
    logic            gender;
    logic [2:0]      ntyped;
    word_t [0:3]     typed;
  } number_row_t;

  typedef struct packed {
    word_t code;
    logic  last;
  } spoken_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] value_i;
  logic        unit_gender_i;
  logic        out_valid_o;
  logic        out_ready_i;
  word_t       word_code_o;
  logic        last_word_o;

  spoken_word_t spelled_q [$];
  word_t        phrase_q [$];
  number_row_t  cur_row;
  bit           mismatch_seen;
  bit           calm;

  number_row_t dir_rows [NumDirected] = '{
    '{32'd0, 1'b0, 3'd2, '{W_ZERO, W_UNIT + FORM_MANY, W_ZERO, W_ZERO}},
    '{32'd0, 1'b1, 3'd2, '{W_ZERO, W_UNIT + FORM_MANY, W_ZERO, W_ZERO}},
    '{32'd1, 1'b0, 3'd2, '{W_ONE, W_UNIT + FORM_ONE, W_ZERO, W_ZERO}},
    '{32'd1, 1'b1, 3'd2, '{W_ONE_F, W_UNIT + FORM_ONE, W_ZERO, W_ZERO}},
    '{32'd2, 1'b1, 3'd2, '{W_TWO_F, W_UNIT + FORM_FEW, W_ZERO, W_ZERO}},
    '{32'hFFFF_FFFF, 1'b0, 3'd3, '{W_MINUS, W_ONE, W_UNIT + FORM_ONE, W_ZERO}},
    '{32'd1000, 1'b0, 3'd3,
      '{W_ONE_F, W_THOUSAND + FORM_ONE, W_UNIT + FORM_MANY, W_ZERO}},
    '{32'd1000000000, 1'b1, 3'd3,
      '{W_ONE, W_BILLION + FORM_ONE, W_UNIT + FORM_MANY, W_ZERO}},
    '{32'd2, 1'b0, 3'd0, '0},
    '{32'd11, 1'b0, 3'd0, '0},
    '{32'd12, 1'b1, 3'd0, '0},
    '{32'd14, 1'b0, 3'd0, '0},
    '{32'd21, 1'b1, 3'd0, '0},
    '{32'd100, 1'b0, 3'd0, '0},
    '{32'd101, 1'b1, 3'd0, '0},
    '{32'd512, 1'b1, 3'd0, '0},
    '{32'd1001, 1'b1, 3'd0, '0},
    '{32'd2000, 1'b0, 3'd0, '0},
    '{32'd1000000, 1'b0, 3'd0, '0},
    '{32'h7FFF_FFFF, 1'b0, 3'd0, '0},
    '{32'h8000_0000, 1'b1, 3'd0, '0},
    '{32'd999999999, 1'b0, 3'd0, '0},
    '{32'd111111111, 1'b0, 3'd0, '0},
    '{-32'sd1002003004, 1'b1, 3'd0, '0},
    '{-32'sd2123456789, 1'b1, 3'd0, '0}
  };

  integer_to_russian_word_tokens dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .unit_gender_i (unit_gender_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_code_o   (word_code_o),
    .last_word_o   (last_word_o)
  );

  function automatic void spell_group(input int unsigned grp, input bit fem,
                                      input word_t noun_base);
    int unsigned hund;
    int unsigned rest;
    logic [1:0]  form;
    form = FORM_MANY;
    hund = grp / 100;
    rest = grp % 100;
    if (hund != 0) phrase_q.push_back(word_t'(W_HUNDRED + hund - 1));
    if (rest >= 20) begin
      phrase_q.push_back(word_t'(W_TENS + rest / 10 - 2));
      rest = rest % 10;
    end
    if (rest != 0) begin
      if (rest == 1) form = FORM_ONE;
      else if (rest < 5) form = FORM_FEW;
      if (rest == 1) phrase_q.push_back(fem ? W_ONE_F : W_ONE);
      else if (rest == 2) phrase_q.push_back(fem ? W_TWO_F : W_TWO);
      else phrase_q.push_back(word_t'(W_THREE + rest - 3));
    end
    phrase_q.push_back(word_t'(noun_base + form));
  endfunction

  function automatic void spell_number(input logic [31:0] num, input logic gender);
    int unsigned mag;
    int unsigned part;
    phrase_q.delete();
    if (num == 0) begin
      phrase_q.push_back(W_ZERO);
      phrase_q.push_back(word_t'(W_UNIT + FORM_MANY));
    end else begin
      if (num[31]) begin
        phrase_q.push_back(W_MINUS);
        mag = ~num + 32'd1;
      end else begin
        mag = num;
      end
      part = mag / 1000000000;
      if (part != 0) spell_group(part, 1'b0, W_BILLION);
      mag = mag % 1000000000;
      part = mag / 1000000;
      if (part != 0) spell_group(part, 1'b0, W_MILLION);
      mag = mag % 1000000;
      part = mag / 1000;
      if (part != 0) spell_group(part, 1'b1, W_THOUSAND);
      mag = mag % 1000;
      spell_group(mag, gender, W_UNIT);
    end
    foreach (phrase_q[i]) spelled_q.push_back('{phrase_q[i], i == phrase_q.size() - 1});
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned rand_group();
    case ($urandom_range(0, 9))
      0, 1, 2: return 0;
      3, 4, 5: return 100 * $urandom_range(0, 9) + $urandom_range(1, 19);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic logic [31:0] next_value();
    longint mag;
    longint signed_mag;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      8: return $urandom_range(0, 40) - 20;
      9: begin
        case ($urandom_range(0, 5))
          0: return 32'd0;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'd1;
          default: return 32'h8000_0001;
        endcase
      end
      default: begin
        mag = longint'($urandom_range(0, 2)) * 1000000000 + longint'(rand_group()) * 1000000
            + longint'(rand_group()) * 1000 + longint'(rand_group());
        if (mag > 2147483647) mag = mag - 1000000000;
        signed_mag = $urandom_range(0, 1) ? -mag : mag;
        return signed_mag[31:0];
      end
    endcase
  endfunction

  task automatic send_number(input number_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    value_i       = row.value;
    unit_gender_i = row.gender;
    cur_row       = row;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    spoken_word_t got;
    spoken_word_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (cur_row.ntyped != 0) begin
        for (int i = 0; i < cur_row.ntyped; i++)
          spelled_q.push_back('{cur_row.typed[i], i == cur_row.ntyped - 1});
      end else begin
        spell_number(cur_row.value, cur_row.gender);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{word_code_o, last_word_o};
      if (spelled_q.size() == 0) begin
        $display("%0t: unexpected word: word_code %0d last_word %0b",
                 $time, got.code, got.last);
        mismatch_seen = 1'b1;
      end else begin
        want = spelled_q.pop_front();
        if (got.code != want.code) begin
          $display("%0t: word_code expected %0d actual %0d", $time, want.code, got.code);
          mismatch_seen = 1'b1;
        end
        if (got.last != want.last) begin
          $display("%0t: last_word expected %0b actual %0b", $time, want.last, got.last);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      out_ready_i = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
      if (!calm) begin
        out_ready_i = 1'b0;
        repeat (pick_gap()) @(negedge clk_i);
      end
    end
  end

  initial begin
    number_row_t row;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    unit_gender_i = 1'b0;
    cur_row       = '0;
    mismatch_seen = 1'b0;
    calm          = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_number(dir_rows[i]);

    for (int n = 0; n < NumRandom; n++) begin
      calm       = (n >= 100 && n < 140);
      row        = '0;
      row.value  = next_value();
      row.gender = $urandom_range(0, 1);
      send_number(row);
    end
    calm       = 1'b0;
    in_valid_i = 1'b0;

    while (spelled_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("integer_to_russian_word_tokens: match");
    end else begin
      $display("integer_to_russian_word_tokens: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("integer_to_russian_word_tokens: mismatch");
    $finish;
  end

endmodule
